// ----- src/sahid_pkg.sv -----
// Shared constants, codes and control structs for the seen/hidden id tables.
package sahid_pkg;

  localparam int SEEN_DEPTH   = 1024;
  localparam int HIDDEN_DEPTH = 128;
  localparam int ID_W         = 32;
  localparam int CMD_W        = 2;
  localparam int OUTCOME_W    = 3;

  localparam int SEEN_AW = $clog2(SEEN_DEPTH);
  localparam int SEEN_CW = SEEN_AW + 1;
  localparam int HID_AW  = $clog2(HIDDEN_DEPTH);
  localparam int HID_CW  = HID_AW + 1;
  localparam int IDX_W   = (SEEN_CW > HID_CW) ? SEEN_CW : HID_CW;

  typedef enum logic [CMD_W-1:0] {
    CMD_STORE = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_EXITED          = 3'd0,
    OUT_STORED          = 3'd1,
    OUT_SEEN_FULL       = 3'd2,
    OUT_FOUND           = 3'd3,
    OUT_HIDDEN_KNOWN    = 3'd4,
    OUT_HIDDEN_RECORDED = 3'd5,
    OUT_HIDDEN_FULL     = 3'd6,
    OUT_CLEARED         = 3'd7
  } outcome_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan_start;
    logic scan_en;
    logic sel_hid;
    logic seen_wr;
    logic hid_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic seen_full;
    logic hid_full;
    logic id_zero;
    logic hit;
    logic scan_done;
  } dp_stat_t;

endpackage

// ----- src/sahid_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sahid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/sahid_dp.sv -----
// Datapath: id register, fill counts, scan counter and the two table memories.
module sahid_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [sahid_pkg::ID_W-1:0] in_object_id,
  input  sahid_pkg::dp_cmd_t        cmd,
  output sahid_pkg::dp_stat_t       stat
);
  import sahid_pkg::*;

  logic [ID_W-1:0]    id_r;
  logic [SEEN_CW-1:0] seen_cnt_r, seen_cnt_nxt;
  logic [HID_CW-1:0]  hid_cnt_r, hid_cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   lim;
  logic               issue;
  logic               seen_full, hid_full, id_zero;
  logic [ID_W-1:0]    seen_q, hid_q, cmp_q;

  always_comb begin
    seen_full = (seen_cnt_r == SEEN_CW'(SEEN_DEPTH));
    hid_full  = (hid_cnt_r == HID_CW'(HIDDEN_DEPTH));
    id_zero   = (id_r == '0);
    lim       = cmd.sel_hid ? IDX_W'(hid_cnt_r) : IDX_W'(seen_cnt_r);
    issue     = cmd.scan_en && !cmd.scan_start && (idx_r != lim);
    cmp_q     = cmd.sel_hid ? hid_q : seen_q;

    stat.seen_full = seen_full;
    stat.hid_full  = hid_full;
    stat.id_zero   = id_zero;
    stat.hit       = pend_r && (cmp_q == id_r);
    stat.scan_done = !pend_r && (idx_r == lim);

    seen_cnt_nxt = seen_cnt_r;
    hid_cnt_nxt  = hid_cnt_r;
    // a zero id written into an empty slot leaves that slot empty
    if (cmd.clear) begin
      seen_cnt_nxt = '0;
      hid_cnt_nxt  = '0;
    end else begin
      if (cmd.seen_wr && !id_zero) begin
        seen_cnt_nxt = seen_cnt_r + SEEN_CW'(1);
      end
      if (cmd.hid_wr && !id_zero) begin
        hid_cnt_nxt = hid_cnt_r + HID_CW'(1);
      end
    end

    idx_nxt  = idx_r;
    pend_nxt = pend_r;
    if (cmd.scan_start) begin
      idx_nxt  = '0;
      pend_nxt = 1'b0;
    end else if (cmd.scan_en) begin
      pend_nxt = issue;
      if (issue) begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_cnt_r <= '0;
      hid_cnt_r  <= '0;
      idx_r      <= '0;
      pend_r     <= 1'b0;
    end else begin
      seen_cnt_r <= seen_cnt_nxt;
      hid_cnt_r  <= hid_cnt_nxt;
      idx_r      <= idx_nxt;
      pend_r     <= pend_nxt;
    end
    if (cmd.load) begin
      id_r <= in_object_id;
    end
  end

  sahid_ram #(.WIDTH(ID_W), .DEPTH(SEEN_DEPTH)) u_seen_ram (
    .clk   (clk),
    .we    (cmd.seen_wr),
    .waddr (seen_cnt_r[SEEN_AW-1:0]),
    .wdata (id_r),
    .re    (issue && !cmd.sel_hid),
    .raddr (idx_r[SEEN_AW-1:0]),
    .rdata (seen_q)
  );

  sahid_ram #(.WIDTH(ID_W), .DEPTH(HIDDEN_DEPTH)) u_hid_ram (
    .clk   (clk),
    .we    (cmd.hid_wr),
    .waddr (hid_cnt_r[HID_AW-1:0]),
    .wdata (id_r),
    .re    (issue && cmd.sel_hid),
    .raddr (idx_r[HID_AW-1:0]),
    .rdata (hid_q)
  );

  a_seen_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_cnt_r <= SEEN_CW'(SEEN_DEPTH)) else $error("seen count past depth");
  a_hid_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hid_cnt_r <= HID_CW'(HIDDEN_DEPTH)) else $error("hidden count past depth");
  a_seen_wr_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seen_wr |-> !seen_full) else $error("seen write into full table");
  a_hid_wr_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hid_wr |-> !hid_full) else $error("hidden write into full table");

endmodule

// ----- src/sahid_ctrl.sv -----
// Controller: sequences store, check and clear, and holds the result register.
module sahid_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sahid_pkg::CMD_W-1:0]   in_cmd,
  input  logic                          in_handle_table_live,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_visible,
  output logic [sahid_pkg::OUTCOME_W-1:0] out_outcome,
  output sahid_pkg::dp_cmd_t            dp_cmd,
  input  sahid_pkg::dp_stat_t           dp_stat
);
  import sahid_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SEEN, S_HID, S_FIN} state_t;

  state_t           state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic             live_r, live_nxt;
  outcome_t         code_r, code_nxt;
  logic             out_valid_r, out_valid_nxt;
  outcome_t         out_code_r, out_code_nxt;
  logic             out_vis_r, out_vis_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    live_nxt      = live_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_vis_nxt   = out_vis_r;
    dp_cmd        = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          cmd_nxt     = in_cmd;
          live_nxt    = in_handle_table_live;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        unique case (cmd_r)
          CMD_CLEAR: begin
            dp_cmd.clear = 1'b1;
            code_nxt     = OUT_CLEARED;
          end
          CMD_STORE: begin
            if (!live_r) begin
              code_nxt = OUT_EXITED;
            end else if (dp_stat.seen_full) begin
              code_nxt = OUT_SEEN_FULL;
            end else begin
              dp_cmd.seen_wr = 1'b1;
              code_nxt       = OUT_STORED;
            end
          end
          CMD_CHECK: begin
            // zero matches any empty slot: decide it from the fill counts
            if (!live_r) begin
              code_nxt = OUT_EXITED;
            end else if (dp_stat.id_zero) begin
              if (!dp_stat.seen_full) begin
                code_nxt = OUT_FOUND;
              end else if (!dp_stat.hid_full) begin
                code_nxt = OUT_HIDDEN_KNOWN;
              end else begin
                code_nxt = OUT_HIDDEN_FULL;
              end
            end else begin
              dp_cmd.scan_start = 1'b1;
              state_nxt         = S_SEEN;
            end
          end
          default: begin
            code_nxt = OUT_EXITED;
          end
        endcase
      end
      S_SEEN: begin
        dp_cmd.scan_en = 1'b1;
        if (dp_stat.hit) begin
          code_nxt  = OUT_FOUND;
          state_nxt = S_FIN;
        end else if (dp_stat.scan_done) begin
          dp_cmd.scan_start = 1'b1;
          state_nxt         = S_HID;
        end
      end
      S_HID: begin
        dp_cmd.scan_en = 1'b1;
        dp_cmd.sel_hid = 1'b1;
        if (dp_stat.hit) begin
          code_nxt  = OUT_HIDDEN_KNOWN;
          state_nxt = S_FIN;
        end else if (dp_stat.scan_done) begin
          if (dp_stat.hid_full) begin
            code_nxt = OUT_HIDDEN_FULL;
          end else begin
            dp_cmd.hid_wr = 1'b1;
            code_nxt      = OUT_HIDDEN_RECORDED;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = code_r;
          out_vis_nxt   = (code_r == OUT_STORED) || (code_r == OUT_FOUND);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    live_r     <= live_nxt;
    code_r     <= code_nxt;
    out_code_r <= out_code_nxt;
    out_vis_r  <= out_vis_nxt;
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_visible = out_vis_r;
  assign out_outcome = out_code_r;

  a_vis_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_vis_r == ((out_code_r == OUT_STORED) || (out_code_r == OUT_FOUND))))
    else $error("visible flag disagrees with outcome");
  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result word raised outside finish state");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(dp_cmd.seen_wr && dp_cmd.hid_wr))
    else $error("both tables written at once");

endmodule

// ----- src/seen_and_hidden_id_tables_unit.sv -----
// Top level of the seen/hidden id tables: controller plus datapath.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   input    | in_valid/in_ready, in_cmd, in_object_id,| in
//            | in_handle_table_live                    |
//   result   | out_valid/out_ready, out_visible,       | out
//            | out_outcome                             |
//
// One word at a time. Clear, store and rejected words pass from accept through
// the execute and finish states to the result register. A check walks the seen
// memory then the hidden memory, one entry a cycle on each memory's read port.
// Fill counts track both tables, so reset and clear need no memory sweep.
// A stalled result holds in the output register; the next word is accepted
// meanwhile and waits before its result is loaded.
module seen_and_hidden_id_tables_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sahid_pkg::CMD_W-1:0]     in_cmd,
  input  logic [sahid_pkg::ID_W-1:0]      in_object_id,
  input  logic                            in_handle_table_live,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_visible,
  output logic [sahid_pkg::OUTCOME_W-1:0] out_outcome
);
  import sahid_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  sahid_ctrl u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_handle_table_live (in_handle_table_live),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_visible          (out_visible),
    .out_outcome          (out_outcome),
    .dp_cmd               (dp_cmd),
    .dp_stat              (dp_stat)
  );

  sahid_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_object_id (in_object_id),
    .cmd          (dp_cmd),
    .stat         (dp_stat)
  );

endmodule
